// ===== rtl/core/fepb_pkg.sv =====
// fepb_pkg: shared widths, constants, coefficient tables and request/result types
// for the fast exponential block; no dependencies, used by every file in rtl/core

package fepb_pkg;

  // fixed point formats
  localparam int unsigned FRAC_BITS   = 40;
  localparam int unsigned MANT_BITS   = 52;
  localparam int unsigned COEF_FRAC   = 56;
  localparam int unsigned X_W         = 52;
  localparam int unsigned XMAG_W      = X_W;
  localparam int unsigned L2E_W       = 63;
  localparam int unsigned XPROD_W     = XMAG_W + L2E_W;
  localparam int unsigned SCALE_SHIFT = FRAC_BITS + 62 - MANT_BITS;
  localparam int unsigned TMAG_W      = 63;
  localparam int unsigned T_W         = 64;
  localparam int unsigned ACC_W       = 58;
  localparam int unsigned AMAG_W      = ACC_W - 1;
  localparam int unsigned P_SHIFT     = COEF_FRAC - MANT_BITS;
  localparam int unsigned PM_W        = AMAG_W + 1 - P_SHIFT;
  localparam int unsigned V_W         = T_W + 1;
  localparam int unsigned RES_W       = 64;
  localparam int unsigned NUM_COEF    = 9;
  localparam int unsigned NUM_STEPS   = NUM_COEF - 1;
  localparam int unsigned COEF_IDX_W  = $clog2(NUM_COEF);

  // log2(e) as unsigned Q1.62
  localparam logic [L2E_W-1:0]  L2E_Q62 = 63'd6653256548922161246;
  localparam logic [TMAG_W-1:0] T_CLAMP = TMAG_W'(1536) << MANT_BITS;

  // result word limits and bias
  localparam logic signed [V_W-1:0] V_OVF_LIM = $signed(V_W'(1024) << MANT_BITS);
  localparam logic signed [V_W-1:0] V_UNF_LIM = -$signed(V_W'(1022) << MANT_BITS);
  localparam logic signed [V_W-1:0] V_BIAS    = $signed(V_W'(1023) << MANT_BITS);
  localparam logic [RES_W-1:0]      INF_BITS  = 64'h7FF0_0000_0000_0000;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [T_W-1:0]   tval_t;
  typedef logic signed [V_W-1:0]   vval_t;

  typedef enum logic [1:0] {
    RANGE_NORMAL    = 2'd0,
    RANGE_OVERFLOW  = 2'd1,
    RANGE_UNDERFLOW = 2'd2
  } range_e;

  // input request
  typedef struct packed {
    logic signed [X_W-1:0] x_value;
    logic                  last_in;
  } x_req_t;

  // result item
  typedef struct packed {
    logic [RES_W-1:0] result_bits;
    range_e           range_status;
    logic             last_out;
  } exp_res_t;

  // state carried between horner steps
  typedef struct packed {
    logic  last;
    tval_t t;
    acc_t  acc;
  } horner_t;

  // coefficients with 56 fraction bits, leading zeros pad the short polynomial
  localparam acc_t POLY_FAST [NUM_COEF] = '{
    58'sd0, 58'sd0, 58'sd0, 58'sd0, 58'sd0,
    -58'sd5707260159214117, -58'sd16165366947096992,
    58'sd21872627106311104, 58'sd7703397532707
  };

  localparam acc_t POLY_ACCURATE [NUM_COEF] = '{
    -58'sd135167282569, -58'sd1019502203453, -58'sd11182391236598,
    -58'sd96028565619768, -58'sd693076732603782, -58'sd3999489092982214,
    -58'sd17310144453279830, 58'sd22111075905366972, -58'sd79372
  };

  function automatic acc_t poly_coef(input logic mode, input logic [COEF_IDX_W-1:0] idx);
    acc_t c;
    if (mode) begin
      c = POLY_ACCURATE[idx];
    end else begin
      c = POLY_FAST[idx];
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/fast_exp_polynomial_bits.sv =====
// fast_exp_polynomial_bits: top level of the pipelined e^x approximation
// depends on fepb_pkg, fepb_scale and fepb_horner_step
//
// Usage
//   Request channel: in_valid_i / in_stall_o / in_req_i carry x (Q11.40) and a
//   vector-end flag; a request is taken when valid is high and stall is low.
//   Result channel: out_valid_o / out_stall_i / out_res_o carry the IEEE double
//   pattern, the range status and the copied flag.
//   Config channel: cfg_valid_i / cfg_ready_o / cfg_data_i write precision_mode
//   (0 degree-3 polynomial, 1 degree-8 polynomial); write it only while idle.
// Timing
//   One request per cycle, back to back, while in_stall_o is low. A result
//   passes through 5 scaling stages, 8 horner steps of 4 stages each,
//   3 finishing stages and the output register. The rate is set by the
//   fully pipelined multiplier stages, each holding 4 partial products.
// Reset and stall
//   Reset empties the pipeline and the output buffer and clears precision_mode.
//   When the receiver stalls, one more result goes to a skid register; while
//   that register is full the whole pipeline holds and in_stall_o is high.

module fast_exp_polynomial_bits (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fepb_pkg::x_req_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fepb_pkg::exp_res_t out_res_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);
  import fepb_pkg::*;

  logic       precision_mode_q;
  logic       en;
  logic       deliver, take;

  logic       step_valid [NUM_STEPS+1];
  horner_t    step_data  [NUM_STEPS+1];

  logic [2:0]         fvld_q;
  logic [1:0]         fneg_q;
  logic [2:0]         flast_q;
  tval_t              ft_q [2];
  logic [AMAG_W-1:0]  f1_mag_q;
  acc_t               amag_full;
  logic [AMAG_W:0]    pm_rnd;
  logic [PM_W-1:0]    f2_pm_q;
  vval_t              v_d, v_q, v_biased;
  exp_res_t           res_new;

  exp_res_t           out_q, skid_q;
  logic               out_valid_q, skid_valid_q;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      precision_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      precision_mode_q <= cfg_data_i;
    end
  end

  // pipeline advances while the skid register is free
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // scaling front end
  fepb_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .req_i   (in_req_i),
    .coef0_i (poly_coef(precision_mode_q, '0)),
    .valid_o (step_valid[0]),
    .data_o  (step_data[0])
  );

  // horner steps
  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
    fepb_horner_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (step_valid[i]),
      .data_i  (step_data[i]),
      .coef_i  (poly_coef(precision_mode_q, COEF_IDX_W'(i + 1))),
      .valid_o (step_valid[i+1]),
      .data_o  (step_data[i+1])
    );
  end

  // finishing: magnitude, round to 52 fraction bits, subtract from t
  assign amag_full = step_data[NUM_STEPS].acc[ACC_W-1] ? acc_t'(-step_data[NUM_STEPS].acc)
                                                        : step_data[NUM_STEPS].acc;
  assign pm_rnd    = {1'b0, f1_mag_q} + ((AMAG_W+1)'(1) << (P_SHIFT - 1));
  assign v_d       = fneg_q[1] ? (vval_t'(ft_q[1]) + vval_t'(f2_pm_q))
                               : (vval_t'(ft_q[1]) - vval_t'(f2_pm_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fvld_q <= '0;
    end else if (en) begin
      fvld_q <= {fvld_q[1:0], step_valid[NUM_STEPS]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_mag_q <= amag_full[AMAG_W-1:0];
      fneg_q   <= {fneg_q[0], step_data[NUM_STEPS].acc[ACC_W-1]};
      flast_q  <= {flast_q[1:0], step_data[NUM_STEPS].last};
      ft_q[0]  <= step_data[NUM_STEPS].t;
      ft_q[1]  <= ft_q[0];
      f2_pm_q  <= pm_rnd[AMAG_W:P_SHIFT];
      v_q      <= v_d;
    end
  end

  // range check and biasing
  assign v_biased = v_q + V_BIAS;

  always_comb begin
    res_new.last_out = flast_q[2];
    if (v_q >= V_OVF_LIM) begin
      res_new.result_bits  = INF_BITS;
      res_new.range_status = RANGE_OVERFLOW;
    end else if (v_q < V_UNF_LIM) begin
      res_new.result_bits  = '0;
      res_new.range_status = RANGE_UNDERFLOW;
    end else begin
      res_new.result_bits  = v_biased[RES_W-1:0];
      res_new.range_status = RANGE_NORMAL;
    end
  end

  // output register with skid entry
  assign take    = out_valid_q && !out_stall_i;
  assign deliver = fvld_q[2] && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (deliver) begin
      if (out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (deliver) begin
      if (out_valid_q && !take) begin
        skid_q <= res_new;
      end else begin
        out_q <= res_new;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid entry filled without a stalled output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_res_o.range_status == RANGE_OVERFLOW))
      |-> (out_res_o.result_bits == INF_BITS))
    else $error("overflow status without infinity pattern");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_res_o.range_status == RANGE_UNDERFLOW))
      |-> (out_res_o.result_bits == '0))
    else $error("underflow status with non-zero result");

endmodule

// ===== rtl/core/fepb_scale.sv =====
// fepb_scale: five-stage pipeline forming t = x * log2(e) with 52 fraction bits
// depends on fepb_pkg

module fepb_scale (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  fepb_pkg::x_req_t  req_i,
  input  fepb_pkg::acc_t    coef0_i,
  output logic              valid_o,
  output fepb_pkg::horner_t data_o
);
  import fepb_pkg::*;

  localparam int unsigned M_LO  = XMAG_W / 2;
  localparam int unsigned M_HI  = XMAG_W - M_LO;
  localparam int unsigned L_LO  = 32;
  localparam int unsigned L_HI  = L2E_W - L_LO;
  localparam int unsigned A_W   = M_LO + L2E_W + 1;
  localparam int unsigned B_W   = M_HI + L2E_W + 1;
  localparam int unsigned SUM_W = XPROD_W + 1;
  localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (SCALE_SHIFT - 1);

  logic [4:0] vld_q;

  logic [XMAG_W-1:0]      x_raw;
  logic [XMAG_W-1:0]      mag_d, s1_mag_q;
  logic [4:1]             neg_q, last_q;
  logic [M_LO+L_LO-1:0]   pp00_d, pp00_q;
  logic [M_LO+L_HI-1:0]   pp01_d, pp01_q;
  logic [M_HI+L_LO-1:0]   pp10_d, pp10_q;
  logic [M_HI+L_HI-1:0]   pp11_d, pp11_q;
  logic [A_W-1:0]         a_d, a_q;
  logic [B_W-1:0]         b_d, b_q;
  logic [SUM_W-1:0]       sum, shifted;
  logic [TMAG_W-1:0]      tmag_d, tmag_q;
  tval_t                  t_d;
  horner_t                out_q;

  // stage 1: magnitude of x
  assign x_raw = req_i.x_value;
  assign mag_d = req_i.x_value[X_W-1] ? (~x_raw + XMAG_W'(1)) : x_raw;

  // stage 2: partial products against the constant
  assign pp00_d = s1_mag_q[M_LO-1:0] * L2E_Q62[L_LO-1:0];
  assign pp01_d = s1_mag_q[M_LO-1:0] * L2E_Q62[L2E_W-1:L_LO];
  assign pp10_d = s1_mag_q[XMAG_W-1:M_LO] * L2E_Q62[L_LO-1:0];
  assign pp11_d = s1_mag_q[XMAG_W-1:M_LO] * L2E_Q62[L2E_W-1:L_LO];

  // stage 3: pair sums
  assign a_d = A_W'(pp00_q) + (A_W'(pp01_q) << L_LO);
  assign b_d = B_W'(pp10_q) + (B_W'(pp11_q) << L_LO);

  // stage 4: final sum, round half up, clamp
  assign sum     = SUM_W'(a_q) + (SUM_W'(b_q) << M_LO) + RND;
  assign shifted = sum >> SCALE_SHIFT;
  assign tmag_d  = (shifted > SUM_W'(T_CLAMP)) ? T_CLAMP : shifted[TMAG_W-1:0];

  // stage 5: restore sign
  assign t_d = neg_q[4] ? tval_t'(-tval_t'(tmag_q)) : tval_t'(tmag_q);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_mag_q   <= mag_d;
      neg_q      <= {neg_q[3:1], req_i.x_value[X_W-1]};
      last_q     <= {last_q[3:1], req_i.last_in};
      pp00_q     <= pp00_d;
      pp01_q     <= pp01_d;
      pp10_q     <= pp10_d;
      pp11_q     <= pp11_d;
      a_q        <= a_d;
      b_q        <= b_d;
      tmag_q     <= tmag_d;
      out_q.last <= last_q[4];
      out_q.t    <= t_d;
      out_q.acc  <= coef0_i;
    end
  end

  assign valid_o = vld_q[4];
  assign data_o  = out_q;

endmodule

// ===== rtl/core/fepb_horner_step.sv =====
// fepb_horner_step: one horner step acc = round(acc * f) + c in four stages
// depends on fepb_pkg

module fepb_horner_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  fepb_pkg::horner_t data_i,
  input  fepb_pkg::acc_t    coef_i,
  output logic              valid_o,
  output fepb_pkg::horner_t data_o
);
  import fepb_pkg::*;

  localparam int unsigned A_LO   = 29;
  localparam int unsigned A_HI   = AMAG_W - A_LO;
  localparam int unsigned F_LO   = MANT_BITS / 2;
  localparam int unsigned F_HI   = MANT_BITS - F_LO;
  localparam int unsigned PLO_W  = A_LO + MANT_BITS + 1;
  localparam int unsigned PHI_W  = A_HI + MANT_BITS + 1;
  localparam int unsigned PROD_W = AMAG_W + MANT_BITS + 1;
  localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (MANT_BITS - 1);

  logic [3:0]             vld_q;
  logic [2:0]             neg_q, last_q;
  tval_t                  t_q [3];

  acc_t                   amag_full;
  logic [AMAG_W-1:0]      mag_q;
  logic [MANT_BITS-1:0]   f;
  logic [A_LO+F_LO-1:0]   pp00_d, pp00_q;
  logic [A_LO+F_HI-1:0]   pp01_d, pp01_q;
  logic [A_HI+F_LO-1:0]   pp10_d, pp10_q;
  logic [A_HI+F_HI-1:0]   pp11_d, pp11_q;
  logic [PLO_W-1:0]       lo_d, lo_q;
  logic [PHI_W-1:0]       hi_d, hi_q;
  logic [PROD_W-1:0]      prod;
  logic [AMAG_W-1:0]      r;
  acc_t                   acc_d;
  horner_t                out_q;

  // stage a: magnitude of the accumulator
  assign amag_full = data_i.acc[ACC_W-1] ? acc_t'(-data_i.acc) : data_i.acc;

  // stage b: partial products with the fraction
  assign f      = t_q[0][MANT_BITS-1:0];
  assign pp00_d = mag_q[A_LO-1:0] * f[F_LO-1:0];
  assign pp01_d = mag_q[A_LO-1:0] * f[MANT_BITS-1:F_LO];
  assign pp10_d = mag_q[AMAG_W-1:A_LO] * f[F_LO-1:0];
  assign pp11_d = mag_q[AMAG_W-1:A_LO] * f[MANT_BITS-1:F_LO];

  // stage c: pair sums
  assign lo_d = PLO_W'(pp00_q) + (PLO_W'(pp01_q) << F_LO);
  assign hi_d = PHI_W'(pp10_q) + (PHI_W'(pp11_q) << F_LO);

  // stage d: round magnitude, reapply sign, add coefficient
  assign prod  = PROD_W'(lo_q) + (PROD_W'(hi_q) << A_LO) + RND;
  assign r     = prod[MANT_BITS +: AMAG_W];
  assign acc_d = neg_q[2] ? (coef_i - acc_t'(r)) : (coef_i + acc_t'(r));

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q      <= amag_full[AMAG_W-1:0];
      neg_q      <= {neg_q[1:0], data_i.acc[ACC_W-1]};
      last_q     <= {last_q[1:0], data_i.last};
      t_q[0]     <= data_i.t;
      t_q[1]     <= t_q[0];
      t_q[2]     <= t_q[1];
      pp00_q     <= pp00_d;
      pp01_q     <= pp01_d;
      pp10_q     <= pp10_d;
      pp11_q     <= pp11_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      out_q.last <= last_q[2];
      out_q.t    <= t_q[2];
      out_q.acc  <= acc_d;
    end
  end

  assign valid_o = vld_q[3];
  assign data_o  = out_q;

endmodule
